// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TBP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be true outside reset
`define TBP_NEVER(lbl, clk, rst, expr) \
   `TBP_ASSERT(lbl, clk, rst, !(expr))

`endif

// ----- hw/rtl/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg
// Types and byte codes for the telnet byte parser and line editor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

   localparam int LINE_MAX_DEF = 32;
   localparam int LEN_W        = 7;
   localparam int QDEPTH       = 2;

   localparam logic [7:0] B_IAC   = 8'd255;
   localparam logic [7:0] B_WILL  = 8'd251;
   localparam logic [7:0] B_WONT  = 8'd252;
   localparam logic [7:0] B_DO    = 8'd253;
   localparam logic [7:0] B_DONT  = 8'd254;
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;
   localparam logic [7:0] B_BS    = 8'd8;
   localparam logic [7:0] B_DEL   = 8'd127;
   localparam logic [7:0] B_CR    = 8'd13;
   localparam logic [7:0] B_LF    = 8'd10;
   localparam logic [7:0] B_SPACE = 8'd32;
   localparam logic [7:0] B_TILDE = 8'd126;

   localparam logic CHAN_CLIENT = 1'b0;
   localparam logic CHAN_LINE   = 1'b1;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_CMD,
      PH_OPT
   } phase_type;

   typedef enum logic [1:0] {
      JOB_CMD,
      JOB_ECHO,
      JOB_ERASE,
      JOB_FLUSH
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [7:0]       b0;
      logic [7:0]       b1;
      logic [LEN_W-1:0] len;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEQ,
      ST_FLUSH
   } back_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/tbp_ram.sv -----
// ----------------------------------------------------------------------------
// tbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_queue.sv -----
// ----------------------------------------------------------------------------
// tbp_queue
// Short job queue between the parser front and the output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tbp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire tbp_pkg::job_type push_job,
   input  wire logic             pop,
   output tbp_pkg::job_type      head_job,
   output logic                  empty,
   output logic                  full
);

   localparam int PW = (tbp_pkg::QDEPTH > 1) ? $clog2(tbp_pkg::QDEPTH) : 1;
   localparam int CW = $clog2(tbp_pkg::QDEPTH + 1);

   tbp_pkg::job_type slot_ff [tbp_pkg::QDEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(tbp_pkg::QDEPTH));
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(tbp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(tbp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `TBP_NEVER(a_no_overflow, clock, reset, push && full && !pop)
   `TBP_NEVER(a_no_underflow, clock, reset, pop && empty)

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_front.sv -----
// ----------------------------------------------------------------------------
// tbp_front
// Accepts received bytes, tracks command parsing, echo mode and the line
// store, and queues one output job per byte that produces results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tbp_front #(
   parameter int LINE_MAX = tbp_pkg::LINE_MAX_DEF,
   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          q_full,
   output logic               q_push,
   output tbp_pkg::job_type   q_job,
   input  wire logic          flush_done,
   output logic               ram_we,
   output logic [AW-1:0]      ram_waddr,
   output logic [7:0]         ram_wdata
);

   localparam int LW    = $clog2(LINE_MAX + 1);
   localparam int LEN_W = tbp_pkg::LEN_W;

   tbp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic          echo_ff, echo_in;
   logic [LW-1:0] len_ff, len_in;
   logic          flush_busy_ff, flush_busy_in;
   logic          accept;
   logic [7:0]    b;

   assign req_ready = !q_full && !flush_busy_ff;
   assign accept    = req_valid && req_ready;
   assign b         = req_rx_byte;

   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      echo_in       = echo_ff;
      len_in        = len_ff;
      flush_busy_in = flush_busy_ff && !flush_done;
      q_push        = 1'b0;
      q_job.kind    = tbp_pkg::JOB_CMD;
      q_job.b0      = b;
      q_job.b1      = b;
      q_job.len     = LEN_W'(len_ff);
      ram_we        = 1'b0;
      ram_waddr     = len_ff[AW-1:0];
      ram_wdata     = b;
      if (accept) begin
         unique case (phase_ff)
            tbp_pkg::PH_CMD: begin
               held_in  = b;
               phase_in = tbp_pkg::PH_OPT;
            end
            tbp_pkg::PH_OPT: begin
               phase_in = tbp_pkg::PH_TEXT;
               q_push   = 1'b1;
               priority case (held_ff)
                  tbp_pkg::B_WILL: begin
                     q_job.b0 = (b == tbp_pkg::OPT_ECHO || b == tbp_pkg::OPT_SGA) ?
                                tbp_pkg::B_DO : tbp_pkg::B_DONT;
                  end
                  tbp_pkg::B_WONT: begin
                     q_job.b0 = tbp_pkg::B_DONT;
                  end
                  tbp_pkg::B_DO: begin
                     if (b == tbp_pkg::OPT_ECHO) begin
                        q_job.b0 = tbp_pkg::B_WILL;
                        echo_in  = 1'b1;
                     end else begin
                        q_job.b0 = tbp_pkg::B_WONT;
                     end
                  end
                  tbp_pkg::B_DONT: begin
                     q_job.b0 = tbp_pkg::B_WONT;
                     if (b == tbp_pkg::OPT_ECHO) begin
                        echo_in = 1'b0;
                     end
                  end
                  default: begin
                     q_push = 1'b0;
                  end
               endcase
            end
            default: begin
               phase_in = tbp_pkg::PH_TEXT;
               priority if (b == tbp_pkg::B_IAC) begin
                  phase_in = tbp_pkg::PH_CMD;
               end else if (b == tbp_pkg::B_CR || b == tbp_pkg::B_LF) begin
                  if (len_ff != '0) begin
                     q_push        = 1'b1;
                     q_job.kind    = tbp_pkg::JOB_FLUSH;
                     len_in        = '0;
                     flush_busy_in = 1'b1;
                  end
               end else if (b >= tbp_pkg::B_SPACE && b <= tbp_pkg::B_TILDE) begin
                  if (len_ff < LW'(LINE_MAX)) begin
                     ram_we     = 1'b1;
                     len_in     = len_ff + 1'b1;
                     q_push     = echo_ff;
                     q_job.kind = tbp_pkg::JOB_ECHO;
                  end
               end else if (b == tbp_pkg::B_BS || b == tbp_pkg::B_DEL) begin
                  if (len_ff != '0) begin
                     len_in     = len_ff - 1'b1;
                     q_push     = echo_ff;
                     q_job.kind = tbp_pkg::JOB_ERASE;
                  end
               end else begin
                  phase_in = tbp_pkg::PH_TEXT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tbp_pkg::PH_TEXT;
         held_ff       <= '0;
         echo_ff       <= 1'b1;
         len_ff        <= '0;
         flush_busy_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         echo_ff       <= echo_in;
         len_ff        <= len_in;
         flush_busy_ff <= flush_busy_in;
      end
   end

   `TBP_ASSERT(a_len_bound, clock, reset, len_ff <= LW'(LINE_MAX))
   `TBP_NEVER(a_no_write_in_flush, clock, reset, ram_we && flush_busy_ff)

endmodule

`default_nettype wire

// ----- hw/rtl/tbp_back.sv -----
// ----------------------------------------------------------------------------
// tbp_back
// Output sequencer: expands queued jobs into result beats, reading the line
// store for line flushes, behind a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tbp_back #(
   parameter int LINE_MAX = tbp_pkg::LINE_MAX_DEF,
   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tbp_pkg::job_type head_job,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  flush_done,
   output logic [AW-1:0]         ram_raddr,
   input  wire logic [7:0]       ram_rdata,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_channel,
   output logic                  rsp_last_of_run
);

   localparam int LEN_W = tbp_pkg::LEN_W;

   tbp_pkg::back_state_type state_ff, state_in;
   tbp_pkg::job_type job_ff, job_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             chan_ff, chan_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic             seq_last;
   logic             flush_last;
   logic [7:0]       seq_byte;

   assign out_free   = !valid_ff || rsp_ready;
   assign flush_last = (idx_ff == job_ff.len - 1'b1);

   always_comb begin
      seq_last = 1'b1;
      seq_byte = job_ff.b0;
      unique case (job_ff.kind)
         tbp_pkg::JOB_CMD: begin
            seq_last = (idx_ff == LEN_W'(2));
            if (idx_ff == '0) begin
               seq_byte = tbp_pkg::B_IAC;
            end else if (idx_ff == LEN_W'(1)) begin
               seq_byte = job_ff.b0;
            end else begin
               seq_byte = job_ff.b1;
            end
         end
         tbp_pkg::JOB_ERASE: begin
            seq_last = (idx_ff == LEN_W'(2));
            seq_byte = (idx_ff == LEN_W'(1)) ? tbp_pkg::B_SPACE : tbp_pkg::B_BS;
         end
         tbp_pkg::JOB_ECHO: begin
            seq_last = 1'b1;
            seq_byte = job_ff.b0;
         end
         tbp_pkg::JOB_FLUSH: begin
            seq_last = 1'b1;
            seq_byte = job_ff.b0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      valid_in   = valid_ff && !rsp_ready;
      byte_in    = byte_ff;
      chan_in    = chan_ff;
      last_in    = last_ff;
      q_pop      = 1'b0;
      flush_done = 1'b0;
      ram_raddr  = idx_ff[AW-1:0];
      unique case (state_ff)
         tbp_pkg::ST_IDLE: begin
            ram_raddr = '0;
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = head_job;
               idx_in   = '0;
               state_in = (head_job.kind == tbp_pkg::JOB_FLUSH) ?
                          tbp_pkg::ST_FLUSH : tbp_pkg::ST_SEQ;
            end
         end
         tbp_pkg::ST_SEQ: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = seq_byte;
               chan_in  = tbp_pkg::CHAN_CLIENT;
               last_in  = seq_last;
               idx_in   = idx_ff + 1'b1;
               if (seq_last) begin
                  state_in = tbp_pkg::ST_IDLE;
               end
            end
         end
         tbp_pkg::ST_FLUSH: begin
            if (out_free) begin
               ram_raddr = idx_in[AW-1:0];
               valid_in  = 1'b1;
               byte_in   = ram_rdata;
               chan_in   = tbp_pkg::CHAN_LINE;
               last_in   = flush_last;
               idx_in    = idx_ff + 1'b1;
               ram_raddr = idx_in[AW-1:0];
               if (flush_last) begin
                  flush_done = 1'b1;
                  state_in   = tbp_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = tbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbp_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      chan_ff <= chan_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_channel     = chan_ff;
   assign rsp_last_of_run = last_ff;

   `TBP_NEVER(a_pop_only_idle, clock, reset, q_pop && state_ff != tbp_pkg::ST_IDLE)
   `TBP_NEVER(a_flush_idx_range, clock, reset,
              state_ff == tbp_pkg::ST_FLUSH && idx_ff >= job_ff.len)

endmodule

`default_nettype wire

// ----- hw/rtl/telnet_byte_parser_line_editor_unit.sv -----
// ----------------------------------------------------------------------------
// telnet_byte_parser_line_editor_unit
// Telnet receive-side option negotiation with a small line editor.
// ----------------------------------------------------------------------------
// Path: results pass through the job queue, the sequencer job register and the
//   output register. Throughput: one input beat a cycle while the job queue has
//   room; the output sequencer sends one result beat a cycle while the output is
//   not stalled, and returns to idle to take each new item. A line flush blocks
//   input until its last line beat has been loaded into the output register.
// Reset: synchronous; the line store RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module telnet_byte_parser_line_editor_unit #(
   parameter int LINE_MAX = tbp_pkg::LINE_MAX_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_channel,
   output logic            rsp_last_of_run
);

   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

   tbp_pkg::job_type push_job;
   tbp_pkg::job_type head_job;
   logic             q_push;
   logic             q_pop;
   logic             q_empty;
   logic             q_full;
   logic             flush_done;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [7:0]       ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [7:0]       ram_rdata;

   tbp_front #(
      .LINE_MAX (LINE_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job),
      .flush_done  (flush_done),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   tbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   tbp_ram #(
      .WIDTH (8),
      .DEPTH (LINE_MAX)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tbp_back #(
      .LINE_MAX (LINE_MAX)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .flush_done      (flush_done),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_channel     (rsp_channel),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ----- tb/telnet_byte_parser_line_editor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// telnet_byte_parser_line_editor_unit_tb
// Drives received bytes into the telnet parser and line editor and checks
// every result beat against an in-bench model of the negotiation replies,
// echo and line flush. Covers directed edits and commands, a full line,
// random command and text traffic with idle bursts on both sides, and a
// steady tail with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_byte_parser_line_editor_unit_tb;

   localparam int LINE_LIMIT = tbp_pkg::LINE_MAX_DEF;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       channel;
      logic       last_of_run;
   } rsp_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_channel;
   logic       rsp_last_of_run;

   telnet_byte_parser_line_editor_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_channel     (rsp_channel),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser / editor state
   tbp_pkg::phase_type rx_phase = tbp_pkg::PH_TEXT;
   logic [7:0] held_cmd = 8'd0;
   logic       echo_en  = 1'b1;
   logic [7:0] line_buf [LINE_LIMIT];
   int         line_len = 0;

   rsp_beat_type run_beats [$];
   rsp_beat_type expected_beats [$];
   rsp_beat_type want_beat;
   int         mismatches = 0;
   int         items_sent = 0;
   bit         quiet_tail = 1'b0;
   int         stall_left = 0;

   function automatic void add_beat(input logic [7:0] b, input logic ch);
      rsp_beat_type nb;
      nb.out_byte    = b;
      nb.channel     = ch;
      nb.last_of_run = 1'b0;
      run_beats.insert(run_beats.size(), nb);
   endfunction

   function automatic void add_negotiation(input logic [7:0] cmd, input logic [7:0] opt);
      add_beat(tbp_pkg::B_IAC, tbp_pkg::CHAN_CLIENT);
      add_beat(cmd, tbp_pkg::CHAN_CLIENT);
      add_beat(opt, tbp_pkg::CHAN_CLIENT);
   endfunction

   function automatic void predict_replies(input logic [7:0] b);
      rsp_beat_type nb;
      run_beats.delete();
      case (rx_phase)
         tbp_pkg::PH_CMD: begin
            held_cmd = b;
            rx_phase = tbp_pkg::PH_OPT;
         end
         tbp_pkg::PH_OPT: begin
            rx_phase = tbp_pkg::PH_TEXT;
            case (held_cmd)
               tbp_pkg::B_WILL: begin
                  if (b == tbp_pkg::OPT_ECHO || b == tbp_pkg::OPT_SGA) begin
                     add_negotiation(tbp_pkg::B_DO, b);
                  end else begin
                     add_negotiation(tbp_pkg::B_DONT, b);
                  end
               end
               tbp_pkg::B_WONT: add_negotiation(tbp_pkg::B_DONT, b);
               tbp_pkg::B_DO: begin
                  if (b == tbp_pkg::OPT_ECHO) begin
                     add_negotiation(tbp_pkg::B_WILL, b);
                     echo_en = 1'b1;
                  end else begin
                     add_negotiation(tbp_pkg::B_WONT, b);
                  end
               end
               tbp_pkg::B_DONT: begin
                  add_negotiation(tbp_pkg::B_WONT, b);
                  if (b == tbp_pkg::OPT_ECHO) echo_en = 1'b0;
               end
               default: ;
            endcase
         end
         default: begin
            rx_phase = tbp_pkg::PH_TEXT;
            if (b == tbp_pkg::B_IAC) begin
               rx_phase = tbp_pkg::PH_CMD;
            end else if (b == tbp_pkg::B_CR || b == tbp_pkg::B_LF) begin
               if (line_len > 0) begin
                  for (int i = 0; i < line_len; i++)
                     add_beat(line_buf[i], tbp_pkg::CHAN_LINE);
                  line_len = 0;
               end
            end else if (b >= tbp_pkg::B_SPACE && b <= tbp_pkg::B_TILDE) begin
               if (line_len < LINE_LIMIT) begin
                  line_buf[line_len] = b;
                  line_len++;
                  if (echo_en) add_beat(b, tbp_pkg::CHAN_CLIENT);
               end
            end else if (b == tbp_pkg::B_BS || b == tbp_pkg::B_DEL) begin
               if (line_len > 0) begin
                  line_len--;
                  if (echo_en) begin
                     add_beat(tbp_pkg::B_BS, tbp_pkg::CHAN_CLIENT);
                     add_beat(tbp_pkg::B_SPACE, tbp_pkg::CHAN_CLIENT);
                     add_beat(tbp_pkg::B_BS, tbp_pkg::CHAN_CLIENT);
                  end
               end
            end
         end
      endcase
      for (int i = 0; i < run_beats.size(); i++) begin
         nb = run_beats[i];
         nb.last_of_run = (i == run_beats.size() - 1);
         expected_beats.insert(expected_beats.size(), nb);
      end
   endfunction

   // caller is at a falling edge; returns at the falling edge after the beat
   task automatic send_byte(input logic [7:0] b);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (!req_ready);
      predict_replies(b);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
   endtask

   task automatic send_command(input logic [7:0] cmd, input logic [7:0] opt);
      send_byte(tbp_pkg::B_IAC);
      send_byte(cmd);
      send_byte(opt);
   endtask

   always @(negedge clock) begin
      if (quiet_tail) begin
         rsp_ready = 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  = 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: out_byte %0d channel %0d", rsp_out_byte, rsp_channel);
            mismatches++;
         end else begin
            want_beat = expected_beats.pop_front();
            if (rsp_out_byte !== want_beat.out_byte) begin
               $error("out_byte: expected %0d, got %0d", want_beat.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_channel !== want_beat.channel) begin
               $error("channel: expected %0d, got %0d", want_beat.channel, rsp_channel);
               mismatches++;
            end
            if (rsp_last_of_run !== want_beat.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d",
                      want_beat.last_of_run, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   task automatic test_line_editing();
      send_byte(tbp_pkg::B_BS);     // erase on empty line
      send_byte(tbp_pkg::B_CR);     // flush of empty line
      send_byte(8'd0);
      send_byte(8'd128);
      send_byte(tbp_pkg::B_SPACE);
      send_byte(tbp_pkg::B_TILDE);
      send_byte(tbp_pkg::B_DEL);
      send_byte(8'd31);
      send_byte(8'd113);
      send_byte(tbp_pkg::B_LF);
   endtask

   task automatic test_negotiation();
      send_command(tbp_pkg::B_WILL, tbp_pkg::OPT_SGA);
      send_command(tbp_pkg::B_WILL, 8'd0);
      send_command(tbp_pkg::B_WONT, tbp_pkg::OPT_ECHO);
      send_command(tbp_pkg::B_DO, 8'd7);
      send_command(tbp_pkg::B_DONT, tbp_pkg::OPT_ECHO);
      send_byte(8'd107);        // echo off: silent edits
      send_byte(8'd109);
      send_byte(tbp_pkg::B_DEL);
      send_byte(tbp_pkg::B_CR);
      send_command(tbp_pkg::B_DO, tbp_pkg::OPT_ECHO);
      send_command(tbp_pkg::B_IAC, 8'd0); // doubled IAC
      send_command(8'd241, 8'd254);
   endtask

   task automatic test_full_line();
      for (int i = 0; i < LINE_LIMIT + 2; i++)
         send_byte(8'($urandom_range(tbp_pkg::B_SPACE, tbp_pkg::B_TILDE)));
      send_byte(tbp_pkg::B_CR);
   endtask

   task automatic send_random_chunk();
      logic [7:0] cmd;
      logic [7:0] opt;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(tbp_pkg::B_SPACE, tbp_pkg::B_TILDE)));
         4: send_byte($urandom_range(0, 1) ? tbp_pkg::B_BS : tbp_pkg::B_DEL);
         5: send_byte($urandom_range(0, 1) ? tbp_pkg::B_CR : tbp_pkg::B_LF);
         6, 7: begin
            case ($urandom_range(0, 5))
               0: cmd = tbp_pkg::B_WILL;
               1: cmd = tbp_pkg::B_WONT;
               2: cmd = tbp_pkg::B_DO;
               3: cmd = tbp_pkg::B_DONT;
               4: cmd = tbp_pkg::B_IAC;
               default: cmd = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
               0: opt = tbp_pkg::OPT_ECHO;
               1: opt = tbp_pkg::OPT_SGA;
               default: opt = 8'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 9) == 0) send_byte(tbp_pkg::B_IAC); // broken: cut short
            else send_command(cmd, opt);
         end
         default: send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic test_random_traffic();
      bit paused;
      paused = 1'b0;
      while (items_sent < 190) begin
         send_random_chunk();
         if (!paused && items_sent >= 120) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   task automatic test_steady_stream();
      int start;
      start = items_sent;
      quiet_tail = 1'b1;
      while (items_sent < start + 30) send_random_chunk();
   endtask

   initial begin
      int guard;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_line_editing();
      test_negotiation();
      test_full_line();
      test_random_traffic();
      test_steady_stream();

      req_valid = 1'b0;
      guard = 0;
      while (expected_beats.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (expected_beats.size() != 0) begin
         $error("%0d expected beats never arrived", expected_beats.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_ram.sv
hw/rtl/tbp_queue.sv
hw/rtl/tbp_front.sv
hw/rtl/tbp_back.sv
hw/rtl/telnet_byte_parser_line_editor_unit.sv
tb/telnet_byte_parser_line_editor_unit_tb.sv
